[hdl/tppc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tppc_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 24;
    localparam int CS_N = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

    localparam int ANG_FRAC   = 30;
    localparam int TRIG_SHIFT = 14;
    localparam int PHI_SHL    = ANG_FRAC - 2 * FRAC_BITS;
    localparam int PM_W       = 30;
    localparam int PHI_W      = PM_W + ((PHI_SHL > 0) ? PHI_SHL : 0);
    localparam int HM_W       = 36;
    localparam int M_W        = (PHI_W > HM_W) ? PHI_W : HM_W;
    localparam int RED_N      = M_W - 32;
    localparam int AM_W       = 33;
    localparam int Z_W        = 34;
    localparam int X_W        = 34;
    localparam int C_W        = 18;
    localparam int CHV_W      = C_W + 16;

    localparam int DV_NW = 68;
    localparam int DV_DW = 33;
    localparam int DV_QW = 41;
    localparam int T_W   = DV_QW + 2;

    localparam int FRONT_LAT = RED_N + 6;
    localparam int P0_STG    = FRONT_LAT + CS_N;
    localparam int P6_STG    = P0_STG + 6 + DV_QW;
    localparam int OUT_STG   = P6_STG + DV_QW + 1;

    localparam logic [34:0] PI_Q30      = 35'd3373259426;
    localparam logic [34:0] HALF_PI_Q30 = 35'd1686629713;
    localparam logic [34:0] TWO_PI_Q30  = 35'd6746518852;
    localparam logic signed [X_W-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_Q30 [MAX_STEPS] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    // count * 2^30 / 1000 = count * HQ_K + (count * HQ_R + HQ_H) / 125
    localparam logic [20:0] HQ_K    = 21'd1073741;
    localparam logic [6:0]  HQ_R    = 7'd103;
    localparam logic [5:0]  HQ_H    = 6'd62;
    localparam logic [15:0] RCP125  = 16'd33555;
    localparam int          RCP_SH  = 22;
    localparam logic [6:0]  DIV125  = 7'd125;

    localparam logic [DV_QW-1:0] QCLAMP       = DV_QW'(1) << (DV_QW - 1);
    localparam logic [DV_QW-1:0] RATE_POS_MAX = DV_QW'(32767);
    localparam logic [DV_QW-1:0] RATE_NEG_MAX = DV_QW'(32768);
    localparam logic [7:0]       PP_GAIN      = 8'd200;

    localparam logic [1:0] CFG_HITCH_OFFSET = 2'd0;
    localparam logic [1:0] CFG_WHEELBASE    = 2'd1;
    localparam logic [1:0] CFG_STEER_GAIN   = 2'd2;

    localparam logic [14:0] HITCH_OFFSET_RST = 15'd1229;
    localparam logic [14:0] WHEELBASE_RST    = 15'd2654;
    localparam logic [12:0] STEER_GAIN_RST   = 13'd2441;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ORIGIN = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    typedef struct packed {
        logic signed [15:0] hitch_count;
        logic signed [15:0] cmd_linear;
        logic signed [15:0] cmd_angular;
        logic signed [15:0] look_lateral_cm;
        logic signed [15:0] look_forward_cm;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] trailer_speed;
        logic signed [15:0] trailer_turn_rate;
        logic [1:0]         status;
    } t_out_word;

    typedef struct packed {
        logic signed [Z_W-1:0] z_hitch;
        logic signed [Z_W-1:0] z_steer;
        logic                  flip;
    } t_angles;

    typedef struct packed {
        logic signed [CHV_W-1:0] chv;
        logic                    neg;
    } t_spd_side;

    typedef struct packed {
        logic sat;
        logic origin;
        logic lat_neg;
    } t_rate_side;

    function automatic logic [16:0] abs16(input logic signed [15:0] a);
        logic signed [16:0] e;
        e = {a[15], a};
        return a[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic [C_W-1:0] abs_c(input logic signed [C_W-1:0] a);
        return a[C_W-1] ? C_W'(-a) : C_W'(a);
    endfunction

endpackage
`default_nettype wire

[hdl/tppc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module tppc_front (
    input  logic                 i_clk,
    input  logic signed [15:0]   i_hitch_count,
    input  logic signed [15:0]   i_cmd_angular,
    input  logic [12:0]          i_steer_gain,
    output tppc_pkg::t_angles    o_ang
);

    localparam int M_W  = tppc_pkg::M_W;
    localparam int AM_W = tppc_pkg::AM_W;
    localparam int Z_W  = tppc_pkg::Z_W;
    localparam int RN   = tppc_pkg::RED_N;
    localparam int PM_W = tppc_pkg::PM_W;
    localparam int HM_W = tppc_pkg::HM_W;
    localparam int SH   = tppc_pkg::RCP_SH;
    localparam logic [AM_W-1:0] PI_A   = AM_W'(tppc_pkg::PI_Q30);
    localparam logic [AM_W-1:0] HPI_A  = AM_W'(tppc_pkg::HALF_PI_Q30);
    localparam logic [AM_W-1:0] TPI_A  = AM_W'(tppc_pkg::TWO_PI_Q30);

    logic [16:0]      r0_hmag, r0_wmag;
    logic             r0_hneg, r0_wneg;
    logic [HM_W-1:0]  r1_hq;
    logic [23:0]      r1_x;
    logic [PM_W-1:0]  r1_pm;
    logic             r1_hneg, r1_wneg;
    logic [HM_W-1:0]  r2_hq;
    logic [23:0]      r2_x;
    logic [17:0]      r2_qe;
    logic [PM_W-1:0]  r2_pm;
    logic             r2_hneg, r2_wneg;
    logic [M_W-1:0]   r3_hm, r3_pm;
    logic             r3_hneg, r3_wneg;
    logic [M_W-1:0]   r_rh [RN];
    logic [M_W-1:0]   r_rp [RN];
    logic             r_rhn [RN];
    logic             r_rwn [RN];
    logic [AM_W-1:0]  r7_hm, r7_pm;
    logic             r7_hs, r7_ps;
    logic signed [Z_W-1:0] r8_zh, r8_zp;
    logic             r8_flip;

    logic [39:0]      n_rcp;
    logic [24:0]      n_q125;
    logic             n_corr;
    logic [M_W-1:0]   n_pm;
    logic [AM_W-1:0]  n_mh, n_mp, n_h3, n_p3;
    logic             n_hfold, n_pfold;

    assign n_rcp  = 40'(r1_x) * 40'(tppc_pkg::RCP125);
    assign n_q125 = 25'(r2_qe) * 25'(tppc_pkg::DIV125);
    assign n_corr = n_q125 > 25'(r2_x);

    if (tppc_pkg::PHI_SHL >= 0) begin : g_shl
        assign n_pm = M_W'(r2_pm) << tppc_pkg::PHI_SHL;
    end else begin : g_shr
        assign n_pm = M_W'((r2_pm + (PM_W'(1) << (-tppc_pkg::PHI_SHL - 1)))
                           >> (-tppc_pkg::PHI_SHL));
    end

    always_ff @(posedge i_clk) begin
        r0_hmag <= tppc_pkg::abs16(i_hitch_count);
        r0_hneg <= !i_hitch_count[15] && (i_hitch_count != 16'sd0);
        r0_wmag <= tppc_pkg::abs16(i_cmd_angular);
        r0_wneg <= i_cmd_angular[15];

        r1_hq   <= HM_W'(r0_hmag) * HM_W'(tppc_pkg::HQ_K);
        r1_x    <= 24'(r0_hmag) * 24'(tppc_pkg::HQ_R) + 24'(tppc_pkg::HQ_H);
        r1_pm   <= PM_W'(i_steer_gain) * PM_W'(r0_wmag);
        r1_hneg <= r0_hneg;
        r1_wneg <= r0_wneg;

        r2_hq   <= r1_hq;
        r2_x    <= r1_x;
        r2_qe   <= n_rcp[SH+17:SH];
        r2_pm   <= r1_pm;
        r2_hneg <= r1_hneg;
        r2_wneg <= r1_wneg;

        r3_hm   <= M_W'(r2_hq) + M_W'(r2_qe) - M_W'(n_corr);
        r3_pm   <= n_pm;
        r3_hneg <= r2_hneg;
        r3_wneg <= r2_wneg;
    end

    for (genvar j = 0; j < RN; j++) begin : g_red
        localparam int K = RN - 1 - j;
        localparam logic [M_W:0] SUB = (M_W + 1)'(tppc_pkg::TWO_PI_Q30) << K;
        logic [M_W-1:0] n_h, n_p;
        logic           n_hn, n_wn;
        if (j == 0) begin : g_first
            assign n_h  = r3_hm;
            assign n_p  = r3_pm;
            assign n_hn = r3_hneg;
            assign n_wn = r3_wneg;
        end else begin : g_next
            assign n_h  = r_rh[j-1];
            assign n_p  = r_rp[j-1];
            assign n_hn = r_rhn[j-1];
            assign n_wn = r_rwn[j-1];
        end
        always_ff @(posedge i_clk) begin
            r_rh[j]  <= ({1'b0, n_h} >= SUB) ? M_W'({1'b0, n_h} - SUB) : n_h;
            r_rp[j]  <= ({1'b0, n_p} >= SUB) ? M_W'({1'b0, n_p} - SUB) : n_p;
            r_rhn[j] <= n_hn;
            r_rwn[j] <= n_wn;
        end
    end

    assign n_mh    = r_rh[RN-1][AM_W-1:0];
    assign n_mp    = r_rp[RN-1][AM_W-1:0];
    assign n_hfold = r7_hm > HPI_A;
    assign n_pfold = r7_pm > HPI_A;
    assign n_h3    = n_hfold ? PI_A - r7_hm : r7_hm;
    assign n_p3    = n_pfold ? PI_A - r7_pm : r7_pm;

    always_ff @(posedge i_clk) begin
        r7_hm   <= (n_mh > PI_A) ? TPI_A - n_mh : n_mh;
        r7_hs   <= r_rhn[RN-1] ^ (n_mh > PI_A);
        r7_pm   <= (n_mp > PI_A) ? TPI_A - n_mp : n_mp;
        r7_ps   <= r_rwn[RN-1] ^ (n_mp > PI_A);

        r8_zh   <= (r7_hs ^ n_hfold) ? -$signed(Z_W'(n_h3)) : $signed(Z_W'(n_h3));
        r8_zp   <= (r7_ps ^ n_pfold) ? -$signed(Z_W'(n_p3)) : $signed(Z_W'(n_p3));
        r8_flip <= n_hfold;
    end

    assign o_ang.z_hitch = r8_zh;
    assign o_ang.z_steer = r8_zp;
    assign o_ang.flip    = r8_flip;

endmodule
`default_nettype wire

[hdl/tppc_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
module tppc_cordic (
    input  logic                                  i_clk,
    input  logic signed [tppc_pkg::Z_W-1:0]       i_z,
    output logic signed [tppc_pkg::C_W-1:0]       o_c,
    output logic signed [tppc_pkg::C_W-1:0]       o_s
);

    localparam int N   = tppc_pkg::CS_N;
    localparam int X_W = tppc_pkg::X_W;
    localparam int Z_W = tppc_pkg::Z_W;
    localparam int C_W = tppc_pkg::C_W;
    localparam logic signed [X_W-1:0] TRIG_RND = X_W'(1) <<< (tppc_pkg::TRIG_SHIFT - 1);

    logic signed [X_W-1:0] r_x [N];
    logic signed [X_W-1:0] r_y [N];
    logic signed [Z_W-1:0] r_z [N];
    logic signed [X_W-1:0] n_cr, n_sr;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [X_W-1:0] n_x, n_y;
        logic signed [Z_W-1:0] n_z;
        if (i == 0) begin : g_first
            assign n_x = tppc_pkg::GAIN_Q30;
            assign n_y = '0;
            assign n_z = i_z;
        end else begin : g_next
            assign n_x = r_x[i-1];
            assign n_y = r_y[i-1];
            assign n_z = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!n_z[Z_W-1]) begin
                r_x[i] <= n_x - (n_y >>> i);
                r_y[i] <= n_y + (n_x >>> i);
                r_z[i] <= n_z - tppc_pkg::ATAN_Q30[i];
            end else begin
                r_x[i] <= n_x + (n_y >>> i);
                r_y[i] <= n_y - (n_x >>> i);
                r_z[i] <= n_z + tppc_pkg::ATAN_Q30[i];
            end
        end
    end

    assign n_cr = (r_x[N-1] + TRIG_RND) >>> tppc_pkg::TRIG_SHIFT;
    assign n_sr = (r_y[N-1] + TRIG_RND) >>> tppc_pkg::TRIG_SHIFT;
    assign o_c  = n_cr[C_W-1:0];
    assign o_s  = n_sr[C_W-1:0];

endmodule
`default_nettype wire

[hdl/tppc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module tppc_div (
    input  logic                          i_clk,
    input  logic [tppc_pkg::DV_NW-1:0]    i_num,
    input  logic [tppc_pkg::DV_DW-1:0]    i_den,
    output logic [tppc_pkg::DV_QW-1:0]    o_quo,
    output logic                          o_ovf
);

    localparam int NW = tppc_pkg::DV_NW;
    localparam int DW = tppc_pkg::DV_DW;
    localparam int QW = tppc_pkg::DV_QW;
    localparam int EW = DW + QW;

    logic [NW-1:0] r_r [QW];
    logic [DW-1:0] r_d [QW];
    logic [QW-1:0] r_q [QW];
    logic          r_o [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int B = QW - 1 - j;
        logic [NW-1:0] n_r;
        logic [DW-1:0] n_d;
        logic [QW-1:0] n_q;
        logic          n_o;
        logic [EW-1:0] n_ds;
        logic          n_ge;
        if (j == 0) begin : g_first
            assign n_r = i_num;
            assign n_d = i_den;
            assign n_q = '0;
            assign n_o = EW'(i_num) >= {i_den, {QW{1'b0}}};
        end else begin : g_next
            assign n_r = r_r[j-1];
            assign n_d = r_d[j-1];
            assign n_q = r_q[j-1];
            assign n_o = r_o[j-1];
        end
        assign n_ds = EW'(n_d) << B;
        assign n_ge = EW'(n_r) >= n_ds;
        always_ff @(posedge i_clk) begin
            r_r[j] <= n_ge ? NW'(EW'(n_r) - n_ds) : n_r;
            r_d[j] <= n_d;
            r_q[j] <= n_ge ? (n_q | (QW'(1) << B)) : n_q;
            r_o[j] <= n_o;
        end
    end

    assign o_quo = r_q[QW-1];
    assign o_ovf = r_o[QW-1];

endmodule
`default_nettype wire

[hdl/trailer_pure_pursuit_command_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Trailer pure-pursuit command unit. A word is taken on every cycle that start
// is high (busy never rises) and its result is on o_result with o_valid high for
// exactly one cycle. Its path runs through angle reduction, the two CORDIC
// pipelines side by side (16 CORDIC steps each), the speed products, the 41-step
// speed divider, speed rounding and saturation, the 41-step turn-rate divider and
// the output register. Throughput is one word per cycle. The receiver cannot
// stall; results are not held. Write the registers only while no words are in
// flight.
module trailer_pure_pursuit_command_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tppc_pkg::t_in_word    i_cmd,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [14:0]           i_cfg_data,
    output tppc_pkg::t_out_word   o_result,
    output logic                  o_valid
);

    localparam int C_W   = tppc_pkg::C_W;
    localparam int CHV_W = tppc_pkg::CHV_W;
    localparam int QW    = tppc_pkg::DV_QW;
    localparam int NW    = tppc_pkg::DV_NW;
    localparam int DW    = tppc_pkg::DV_DW;
    localparam int T_W   = tppc_pkg::T_W;
    localparam int CS_N  = tppc_pkg::CS_N;
    localparam int P0    = tppc_pkg::P0_STG;
    localparam int P6    = tppc_pkg::P6_STG;
    localparam int OS    = tppc_pkg::OUT_STG;
    localparam logic signed [T_W-1:0] SPD_RND = T_W'(32768);
    localparam logic signed [T_W-1:0] SPD_MAX = T_W'(32767);
    localparam logic signed [T_W-1:0] SPD_MIN = -T_W'(32768);

    logic [14:0] r_hitch_offset, r_wheelbase;
    logic [12:0] r_steer_gain;
    logic        r_vld [OS+1];
    tppc_pkg::t_in_word   r_a [P6];
    logic                 r_fl [CS_N];
    tppc_pkg::t_spd_side  r_b [QW];
    tppc_pkg::t_rate_side r_c [QW];

    tppc_pkg::t_angles w_ang;
    logic signed [C_W-1:0] w_ch, w_sh, w_ct, w_st;
    logic [QW-1:0] w_q1, w_q2;
    logic          w_o1, w_o2;

    logic signed [C_W-1:0]   r0_ch;
    logic [C_W-1:0]          r0_ash, r0_ast, r0_act;
    logic signed [15:0]      r0_v;
    logic [16:0]             r0_av;
    logic                    r0_neg;
    logic [32:0]             r1_m1, r1_den;
    logic signed [CHV_W-1:0] r1_chv;
    logic [16:0]             r1_av;
    logic [C_W-1:0]          r1_ast;
    logic                    r1_neg;
    logic [49:0]             r2_m2;
    logic [32:0]             r2_den;
    logic signed [CHV_W-1:0] r2_chv;
    logic [C_W-1:0]          r2_ast;
    logic                    r2_neg;
    logic [NW-1:0]           r3_num;
    logic [DW-1:0]           r3_den;
    logic signed [CHV_W-1:0] r3_chv;
    logic                    r3_neg;
    logic signed [T_W-1:0]   r4_term;
    logic signed [CHV_W-1:0] r4_chv;
    logic signed [15:0]      r5_spd;
    logic                    r5_sat;
    logic [37:0]             r6_num;
    logic [31:0]             r6_den;
    logic                    r6_sat, r6_origin, r6_latneg;
    tppc_pkg::t_out_word     r_out;

    logic signed [C_W-1:0]   n_ch, n_sh, n_ct;
    logic [14:0]             n_wb;
    logic [QW-1:0]           n_q1c;
    logic signed [T_W-1:0]   n_t, n_ts;
    logic signed [15:0]      n_lat, n_fwd;
    logic [1:0]              n_st;
    logic signed [15:0]      n_rate;
    logic                    n_sat2;
    tppc_pkg::t_rate_side    n_cs;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hitch_offset <= tppc_pkg::HITCH_OFFSET_RST;
            r_wheelbase    <= tppc_pkg::WHEELBASE_RST;
            r_steer_gain   <= tppc_pkg::STEER_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tppc_pkg::CFG_HITCH_OFFSET: r_hitch_offset <= i_cfg_data;
                tppc_pkg::CFG_WHEELBASE:    r_wheelbase    <= i_cfg_data;
                tppc_pkg::CFG_STEER_GAIN:   r_steer_gain   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= OS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k <= OS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0] <= i_cmd;
        for (int k = 1; k < P6; k++) begin
            r_a[k] <= r_a[k-1];
        end
        r_fl[0] <= w_ang.flip;
        for (int k = 1; k < CS_N; k++) begin
            r_fl[k] <= r_fl[k-1];
        end
        r_b[0] <= '{chv: r3_chv, neg: r3_neg};
        r_c[0] <= n_cs;
        for (int k = 1; k < QW; k++) begin
            r_b[k] <= r_b[k-1];
            r_c[k] <= r_c[k-1];
        end
    end

    tppc_front u_front (
        .i_clk         (i_clk),
        .i_hitch_count (i_cmd.hitch_count),
        .i_cmd_angular (i_cmd.cmd_angular),
        .i_steer_gain  (r_steer_gain),
        .o_ang         (w_ang)
    );

    tppc_cordic u_cord_hitch (
        .i_clk (i_clk),
        .i_z   (w_ang.z_hitch),
        .o_c   (w_ch),
        .o_s   (w_sh)
    );

    tppc_cordic u_cord_steer (
        .i_clk (i_clk),
        .i_z   (w_ang.z_steer),
        .o_c   (w_ct),
        .o_s   (w_st)
    );

    assign n_ch = r_fl[CS_N-1] ? -w_ch : w_ch;
    assign n_sh = r_fl[CS_N-1] ? -w_sh : w_sh;
    assign n_ct = (w_ct == '0) ? C_W'(1) : w_ct;
    assign n_wb = (r_wheelbase == '0) ? 15'd1 : r_wheelbase;

    // speed: cos(h)*v - off*sin(h)*v*tan(phi)/L
    always_ff @(posedge i_clk) begin
        r0_ch  <= n_ch;
        r0_ash <= tppc_pkg::abs_c(n_sh);
        r0_ast <= tppc_pkg::abs_c(w_st);
        r0_act <= tppc_pkg::abs_c(n_ct);
        r0_v   <= r_a[P0-1].cmd_linear;
        r0_av  <= tppc_pkg::abs16(r_a[P0-1].cmd_linear);
        r0_neg <= !(n_sh[C_W-1] ^ r_a[P0-1].cmd_linear[15] ^ w_st[C_W-1] ^ n_ct[C_W-1]);

        r1_m1  <= 33'(r_hitch_offset) * 33'(r0_ash);
        r1_den <= 33'(n_wb) * 33'(r0_act);
        r1_chv <= CHV_W'(r0_ch) * CHV_W'(r0_v);
        r1_av  <= r0_av;
        r1_ast <= r0_ast;
        r1_neg <= r0_neg;

        r2_m2  <= 50'(r1_m1) * 50'(r1_av);
        r2_den <= r1_den;
        r2_chv <= r1_chv;
        r2_ast <= r1_ast;
        r2_neg <= r1_neg;

        r3_num <= NW'(r2_m2) * NW'(r2_ast);
        r3_den <= DW'(r2_den);
        r3_chv <= r2_chv;
        r3_neg <= r2_neg;
    end

    tppc_div u_div_spd (
        .i_clk (i_clk),
        .i_num (r3_num),
        .i_den (r3_den),
        .o_quo (w_q1),
        .o_ovf (w_o1)
    );

    assign n_q1c = (w_o1 || (w_q1 > tppc_pkg::QCLAMP)) ? tppc_pkg::QCLAMP : w_q1;
    assign n_t   = r4_term + T_W'(r4_chv) + SPD_RND;
    assign n_ts  = n_t >>> 16;
    assign n_lat = r_a[P6-1].look_lateral_cm;
    assign n_fwd = r_a[P6-1].look_forward_cm;
    assign n_cs  = '{sat: r6_sat, origin: r6_origin, lat_neg: r6_latneg};

    always_ff @(posedge i_clk) begin
        r4_term <= r_b[QW-1].neg ? -$signed(T_W'(n_q1c)) : $signed(T_W'(n_q1c));
        r4_chv  <= r_b[QW-1].chv;

        if (n_ts > SPD_MAX) begin
            r5_spd <= 16'sd32767;
            r5_sat <= 1'b1;
        end else if (n_ts < SPD_MIN) begin
            r5_spd <= -16'sd32768;
            r5_sat <= 1'b1;
        end else begin
            r5_spd <= n_ts[15:0];
            r5_sat <= 1'b0;
        end

        r6_num    <= 38'(38'(tppc_pkg::abs16(n_lat)) * 38'(tppc_pkg::abs16(r5_spd)))
                     * 38'(tppc_pkg::PP_GAIN);
        r6_den    <= 32'(32'($signed(n_lat) * $signed(n_lat)))
                     + 32'(32'($signed(n_fwd) * $signed(n_fwd)));
        r6_origin <= (n_lat == 16'sd0) && (n_fwd == 16'sd0);
        r6_latneg <= n_lat[15];
        r6_sat    <= r5_sat;
    end

    // turn rate: round(200*|lat|*|speed| / (lat^2 + fwd^2))
    tppc_div u_div_rate (
        .i_clk (i_clk),
        .i_num (NW'({r6_num, 1'b0}) + NW'(r6_den)),
        .i_den (DW'({r6_den, 1'b0})),
        .o_quo (w_q2),
        .o_ovf (w_o2)
    );

    always_comb begin
        n_sat2 = 1'b0;
        if (r_c[QW-1].origin) begin
            n_rate = '0;
        end else if (r_c[QW-1].lat_neg) begin
            if (w_o2 || (w_q2 > tppc_pkg::RATE_NEG_MAX)) begin
                n_rate = -16'sd32768;
                n_sat2 = 1'b1;
            end else begin
                n_rate = 16'(-$signed({1'b0, w_q2[15:0]}));
            end
        end else begin
            if (w_o2 || (w_q2 > tppc_pkg::RATE_POS_MAX)) begin
                n_rate = 16'sd32767;
                n_sat2 = 1'b1;
            end else begin
                n_rate = $signed(w_q2[15:0]);
            end
        end
        if (r_c[QW-1].sat || n_sat2) begin
            n_st = tppc_pkg::ST_SAT;
        end else if (r_c[QW-1].origin) begin
            n_st = tppc_pkg::ST_ORIGIN;
        end else begin
            n_st = tppc_pkg::ST_OK;
        end
    end

    logic signed [15:0] r_spd_d [QW+1];

    always_ff @(posedge i_clk) begin
        r_spd_d[0] <= r5_spd;
        for (int k = 1; k <= QW; k++) begin
            r_spd_d[k] <= r_spd_d[k-1];
        end
        r_out.trailer_speed     <= r_spd_d[QW];
        r_out.trailer_turn_rate <= n_rate;
        r_out.status            <= n_st;
    end

    assign o_result = r_out;
    assign o_valid  = r_vld[OS];

endmodule
`default_nettype wire

[tb/tb_trailer_pure_pursuit_command_unit.sv]
`timescale 1ns / 1ps
module tb_trailer_pure_pursuit_command_unit;
    import tppc_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 200000;
    localparam longint TWO_PI = 64'sd6746518852;
    localparam longint PI     = 64'sd3373259426;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    localparam longint ATAN_TBL [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_cmd;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [14:0] i_cfg_data;
    t_out_word   o_result;
    logic        o_valid;

    trailer_pure_pursuit_command_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_result(o_result), .o_valid(o_valid)
    );

    longint unsigned offset_m, wheelbase_m, gain_m;

    t_in_word  cmd_q[$];
    t_out_word result_q[$];
    int  idle_pct;
    bit  hold_tx;
    int  errors;
    int  words_sent;
    int  words_checked;
    int  origin_seen;
    int  sat_seen;
    int  cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint wrap_angle(longint a);
        longint m;
        m = (a < 0) ? -a : a;
        m = m % TWO_PI;
        a = (a < 0) ? -m : m;
        if (a > PI) a -= TWO_PI;
        if (a < -PI) a += TWO_PI;
        return a;
    endfunction

    function automatic void cordic_sincos(input longint z, output longint c,
                                          output longint s);
        longint x, y, dx, dy;
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        c = (x + 64'sd8192) >>> 14;
        s = (y + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp16(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic t_out_word predict_command(t_in_word c);
        longint cnt, v, w, lat, fwd, h, ch, sh, phi, ct, st, t, spd, rate, sgn;
        longint unsigned mag, num, den, q, wb;
        int shf;
        bit sat, origin;
        t_out_word r;
        cnt = c.hitch_count;
        v = c.cmd_linear;
        w = c.cmd_angular;
        lat = c.look_lateral_cm;
        fwd = c.look_forward_cm;
        sat = 1'b0;
        origin = 1'b0;
        shf = 2 * FRAC_BITS - 30;

        mag = (cnt < 0) ? -cnt : cnt;
        h = ((mag << 30) + 500) / 1000;
        if (cnt > 0) h = -h;
        h = wrap_angle(h);
        sgn = 1;
        if (h > HALF_PI) begin
            h -= PI; sgn = -1;
        end else if (h < -HALF_PI) begin
            h += PI; sgn = -1;
        end
        cordic_sincos(h, ch, sh);
        ch *= sgn;
        sh *= sgn;

        mag = gain_m * longint'((w < 0) ? -w : w);
        if (shf <= 0) mag = mag << (-shf);
        else mag = (mag + (64'd1 << (shf - 1))) >> shf;
        phi = mag;
        if (w < 0) phi = -phi;
        phi = wrap_angle(phi);
        if (phi > HALF_PI) phi -= PI;
        else if (phi < -HALF_PI) phi += PI;
        cordic_sincos(phi, ct, st);
        if (ct == 0) ct = 1;

        wb = (wheelbase_m != 0) ? wheelbase_m : 1;
        num = offset_m * longint'((sh < 0) ? -sh : sh);
        num *= longint'((v < 0) ? -v : v);
        num *= longint'((st < 0) ? -st : st);
        den = wb * longint'((ct < 0) ? -ct : ct);
        q = num / den;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        sgn = -1;
        if (sh < 0) sgn = -sgn;
        if (v < 0) sgn = -sgn;
        if (st < 0) sgn = -sgn;
        if (ct < 0) sgn = -sgn;
        t = ch * v + ((sgn < 0) ? -longint'(q) : longint'(q));
        spd = (t + 64'sd32768) >>> 16;
        spd = clamp16(spd, sat);

        den = lat * lat + fwd * fwd;
        if (den == 0) begin
            origin = 1'b1;
            rate = 0;
        end else begin
            num = 200 * longint'((lat < 0) ? -lat : lat) * longint'((spd < 0) ? -spd : spd);
            q = (2 * num + den) / (2 * den);
            if (q > 65536) q = 65536;
            rate = (lat < 0) ? -longint'(q) : longint'(q);
            rate = clamp16(rate, sat);
        end

        r.trailer_speed = spd[15:0];
        r.trailer_turn_rate = rate[15:0];
        r.status = sat ? ST_SAT : (origin ? ST_ORIGIN : ST_OK);
        return r;
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) begin
                result_q.push_back(predict_command(i_cmd));
                words_sent++;
            end
            if (cmd_q.size() > 0 && !hold_tx && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= cmd_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid) begin
            if (result_q.size() == 0) begin
                $error("unexpected result word %h", o_result);
                errors++;
            end else begin
                e = result_q.pop_front();
                words_checked++;
                if (e.status == ST_ORIGIN) origin_seen++;
                if (e.status == ST_SAT) sat_seen++;
                if (o_result.trailer_speed !== e.trailer_speed) begin
                    $error("trailer_speed exp %0d got %0d", e.trailer_speed,
                           o_result.trailer_speed);
                    errors++;
                end
                if (o_result.trailer_turn_rate !== e.trailer_turn_rate) begin
                    $error("trailer_turn_rate exp %0d got %0d", e.trailer_turn_rate,
                           o_result.trailer_turn_rate);
                    errors++;
                end
                if (o_result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_result.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_HITCH_OFFSET: offset_m = data;
            CFG_WHEELBASE:    wheelbase_m = data;
            CFG_STEER_GAIN:   gain_m = data[12:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [14:0] off, input logic [14:0] wb,
                              input logic [14:0] gain);
        write_reg(CFG_HITCH_OFFSET, off);
        write_reg(CFG_WHEELBASE, wb);
        write_reg(CFG_STEER_GAIN, gain);
        write_reg(CFG_UNUSED, 15'($urandom_range(32767)));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        wait (cmd_q.size() == 0 && !start && result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_word random_cmd();
        t_in_word c;
        int k;
        k = $urandom_range(7);
        c = 80'({$urandom, $urandom, $urandom});
        if (k == 0) begin
            c.look_lateral_cm = '0;
            c.look_forward_cm = '0;
        end else if (k == 1) begin
            c.hitch_count = 16'($signed($urandom_range(3200)) - 1600);
            c.cmd_linear = 16'($signed($urandom_range(8192)) - 4096);
            c.cmd_angular = 16'($signed($urandom_range(8192)) - 4096);
            c.look_lateral_cm = 16'($signed($urandom_range(400)) - 200);
            c.look_forward_cm = 16'($urandom_range(400));
        end else if (k == 2) begin
            c.look_lateral_cm = 16'($signed($urandom_range(20)) - 10);
            c.look_forward_cm = 16'($signed($urandom_range(20)) - 10);
        end
        return c;
    endfunction

    task automatic add_directed;
        t_in_word c;
        logic signed [15:0] ext [4];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
        for (int i = 0; i < 4; i++) begin
            c = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4], ext[i]};
            cmd_q.push_back(c);
        end
        cmd_q.push_back('{16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0});
        cmd_q.push_back('{16'sd200, 16'sd4096, 16'sd1000, 16'sd0, 16'sd0});
        cmd_q.push_back('{-16'sd1571, 16'sd4096, 16'sd0, 16'sd50, 16'sd200});
        cmd_q.push_back('{16'sd1571, -16'sd4096, 16'sd0, -16'sd50, 16'sd200});
        cmd_q.push_back('{16'sd3142, 16'sd4096, 16'sd0, 16'sd100, 16'sd0});
        cmd_q.push_back('{16'sd6283, 16'sd2048, -16'sd500, 16'sd0, -16'sd100});
        cmd_q.push_back('{16'sd500, 16'sd32767, 16'sd32767, 16'sd1, 16'sd0});
        cmd_q.push_back('{-16'sd500, -16'sd32768, -16'sd32768, -16'sd1, 16'sd0});
        cmd_q.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd1, 16'sd1});
        cmd_q.push_back('{16'sd0, -16'sd32768, 16'sd0, -16'sd1, 16'sd1});
        cmd_q.push_back('{16'sd0, 16'sd4096, 16'sd643, 16'sd10, 16'sd100});
        cmd_q.push_back('{16'sd700, 16'sd4096, -16'sd643, 16'sd30, 16'sd30});
        cmd_q.push_back('{-16'sd30000, 16'sd1000, 16'sd20000, -16'sd32768, 16'sd32767});
        cmd_q.push_back('{16'sd30000, 16'sd1000, -16'sd20000, 16'sd32767, -16'sd32768});
    endtask

    task automatic run_random(input int n, input int pct);
        idle_pct = pct;
        for (int i = 0; i < n; i++) cmd_q.push_back(random_cmd());
        wait (cmd_q.size() < n / 2);
        hold_tx = 1'b1;
        wait (!start && result_q.size() == 0);
        hold_tx = 1'b0;
        drain();
    endtask

    initial begin
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_HITCH_OFFSET;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        offset_m = HITCH_OFFSET_RST;
        wheelbase_m = WHEELBASE_RST;
        gain_m = STEER_GAIN_RST;
        idle_pct = 0;
        hold_tx = 1'b0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        origin_seen = 0;
        sat_seen = 0;
        cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_directed();
        drain();
        run_random(130, 0);
        set_config(15'd32767, 15'd1, 15'd8191);
        run_random(130, 60);
        set_config(15'd0, 15'd32767, 15'd0);
        run_random(120, 12);
        set_config(15'd1229, 15'd0, 15'd2441);
        run_random(120, 60);
        set_config(15'($urandom_range(32767)), 15'($urandom_range(1, 32767)),
                   15'($urandom_range(8191)));
        run_random(130, 12);
        set_config(15'd32767, 15'd32767, 15'd8191);
        run_random(120, 0);
        set_config(15'd1229, 15'd2654, 15'd2441);
        run_random(130, 60);

        $display("Sent %0d command words over 7 register settings, checked %0d results",
                 words_sent, words_checked);
        $display("Results at origin: %0d, saturated: %0d", origin_seen, sat_seen);
        if (errors == 0 && result_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
